// ===== src/msrg_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and the microcode table of the mecanum step rate generator
// no dependencies; used by msrg_seq, msrg_datapath and the top level

package msrg_pkg;

  // defaults of the top level parameters
  localparam int FRACTION_BITS_DEF = 14;
  localparam int COUNTER_BITS_DEF  = 13;

  // fixed field widths
  localparam int CMD_W       = 9;
  localparam int TGT_W       = 11;
  localparam int CFG_W       = 12;
  localparam int CFG_IDX_W   = 2;
  localparam int PERIOD_W    = 12;
  localparam int NUM_WHEELS  = 4;
  localparam int WHEEL_IDX_W = 2;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_FACTOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER_LIMIT = 2'd2;

  // filter weights in q0.16, signed 18 bit operands
  localparam int COEF_OLD   = 63898;
  localparam int COEF_NEW   = 1638;
  localparam int COEF_W     = 18;
  localparam int COEF_SHIFT = 16;
  localparam int ROUND_BIAS = 32768;

  // speed bands in whole units of the wheel value
  localparam int FULL_SPEED_LIMIT    = 100;
  localparam int STOP_LIMIT          = 13;
  // 100 fits in 7 bits, 100 * 255 fits in 15 bits
  localparam int FULL_SPEED_BITS     = 7;
  localparam int DIVIDEND_SCALE_BITS = 15;
  // middle band quotient stays below 100 * 255 / 13 < 2^11
  localparam int QUOT_BITS           = 11;

  // microcode operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_MUL,
    OP_FILT,
    OP_BAND,
    OP_PERIOD,
    OP_NEXT_WHEEL,
    OP_TICK,
    OP_EMIT
  } op_t;

  // jump conditions
  typedef enum logic [2:0] {
    COND_NONE,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_TICK,
    COND_EDGE_BAND,
    COND_DIV_BUSY,
    COND_MORE_WHEELS,
    COND_OUT_BUSY
  } cond_t;

  // program addresses
  localparam int PC_W = 4;
  localparam logic [PC_W-1:0] PC_IDLE       = 4'd0;
  localparam logic [PC_W-1:0] PC_DISPATCH   = 4'd1;
  localparam logic [PC_W-1:0] PC_MUL        = 4'd2;
  localparam logic [PC_W-1:0] PC_FILT       = 4'd3;
  localparam logic [PC_W-1:0] PC_BAND       = 4'd4;
  localparam logic [PC_W-1:0] PC_DIV_WAIT   = 4'd5;
  localparam logic [PC_W-1:0] PC_PERIOD     = 4'd6;
  localparam logic [PC_W-1:0] PC_NEXT_WHEEL = 4'd7;
  localparam logic [PC_W-1:0] PC_OUT_WAIT   = 4'd8;
  localparam logic [PC_W-1:0] PC_EMIT       = 4'd9;
  localparam logic [PC_W-1:0] PC_TICK       = 4'd10;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } uword_t;

  // sequencer to datapath
  typedef struct packed {
    op_t  op;
    logic accept;
  } ctrl_t;

  // datapath to sequencer
  typedef struct packed {
    logic req_tick;
    logic band_edge;
    logic div_busy;
    logic last_wheel;
    logic out_busy;
  } stat_t;

  // control store: jump to target when cond holds, else fall through
  function automatic uword_t ucode_rom(input logic [PC_W-1:0] pc);
    uword_t w;
    unique case (pc)
      PC_IDLE:       w = '{OP_ACCEPT,     COND_NO_INPUT,    PC_IDLE};
      PC_DISPATCH:   w = '{OP_NOP,        COND_TICK,        PC_TICK};
      PC_MUL:        w = '{OP_MUL,        COND_NONE,        PC_IDLE};
      PC_FILT:       w = '{OP_FILT,       COND_NONE,        PC_IDLE};
      PC_BAND:       w = '{OP_BAND,       COND_EDGE_BAND,   PC_NEXT_WHEEL};
      PC_DIV_WAIT:   w = '{OP_NOP,        COND_DIV_BUSY,    PC_DIV_WAIT};
      PC_PERIOD:     w = '{OP_PERIOD,     COND_NONE,        PC_IDLE};
      PC_NEXT_WHEEL: w = '{OP_NEXT_WHEEL, COND_MORE_WHEELS, PC_MUL};
      PC_OUT_WAIT:   w = '{OP_NOP,        COND_OUT_BUSY,    PC_OUT_WAIT};
      PC_EMIT:       w = '{OP_EMIT,       COND_ALWAYS,      PC_IDLE};
      PC_TICK:       w = '{OP_TICK,       COND_ALWAYS,      PC_OUT_WAIT};
      default:       w = '{OP_NOP,        COND_ALWAYS,      PC_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== src/msrg_seq.sv =====
`timescale 1ns / 1ps
// microcode sequencer: program counter, control store lookup and jump logic
// depends on msrg_pkg

module msrg_seq (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  msrg_pkg::stat_t stat,
  output msrg_pkg::ctrl_t ctrl
);
  import msrg_pkg::*;

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  uword_t          uword;
  logic            take_jump;

  // control word of the current step
  assign uword = ucode_rom(pc);

  // jump condition select
  always_comb begin
    unique case (uword.cond)
      COND_NONE:        take_jump = 1'b0;
      COND_ALWAYS:      take_jump = 1'b1;
      COND_NO_INPUT:    take_jump = !in_valid;
      COND_TICK:        take_jump = stat.req_tick;
      COND_EDGE_BAND:   take_jump = stat.band_edge;
      COND_DIV_BUSY:    take_jump = stat.div_busy;
      COND_MORE_WHEELS: take_jump = !stat.last_wheel;
      COND_OUT_BUSY:    take_jump = stat.out_busy;
      default:          take_jump = 1'b1;
    endcase
  end

  assign pc_next = take_jump ? uword.target : pc + PC_W'(1);

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  // control out
  assign in_ready    = (uword.op == OP_ACCEPT);
  assign ctrl.op     = uword.op;
  assign ctrl.accept = (uword.op == OP_ACCEPT) && in_valid;

endmodule

// ===== src/msrg_div.sv =====
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle, quotient known to fit in QUOT_W bits
// no package dependency

module msrg_div #(
  parameter int DIVIDEND_W = 29,
  parameter int DIVISOR_W  = 21,
  parameter int QUOT_W     = 11
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  busy,
  output logic [QUOT_W-1:0]     quotient
);
  localparam int SHIFT_W = DIVISOR_W + QUOT_W - 1;
  localparam int REM_W   = (DIVIDEND_W > SHIFT_W) ? DIVIDEND_W : SHIFT_W;
  localparam int CNT_W   = (QUOT_W > 1) ? $clog2(QUOT_W) : 1;

  logic [REM_W-1:0] rem;
  logic [REM_W-1:0] sd;
  logic [CNT_W-1:0] cnt;
  logic             fits;

  assign fits = (rem >= sd);

  // bit counter and busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(QUOT_W - 1);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - CNT_W'(1);
      end
    end
  end

  // remainder, shifted divisor and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= REM_W'(dividend);
      sd       <= REM_W'(divisor) << (QUOT_W - 1);
      quotient <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= rem - sd;
      end
      sd       <= sd >> 1;
      quotient <= {quotient[QUOT_W-2:0], fits};
    end
  end

endmodule

// ===== src/msrg_datapath.sv =====
`timescale 1ns / 1ps
// datapath: config registers, wheel filter, period curve, tick counters, result register
// depends on msrg_pkg and msrg_div

module msrg_datapath #(
  parameter int FRACTION_BITS = msrg_pkg::FRACTION_BITS_DEF,
  parameter int COUNTER_BITS  = msrg_pkg::COUNTER_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  msrg_pkg::ctrl_t                      ctrl,
  output msrg_pkg::stat_t                      stat,
  input  logic                                 cfg_we,
  input  logic [msrg_pkg::CFG_IDX_W-1:0]       cfg_addr,
  input  logic [msrg_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                 req_type,
  input  logic signed [msrg_pkg::CMD_W-1:0]    rotation,
  input  logic signed [msrg_pkg::CMD_W-1:0]    forward,
  input  logic signed [msrg_pkg::CMD_W-1:0]    lateral,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [msrg_pkg::NUM_WHEELS-1:0]      step_levels,
  output logic [msrg_pkg::NUM_WHEELS-1:0]      direction_levels,
  output logic [msrg_pkg::PERIOD_W-1:0]        period_front_left,
  output logic [msrg_pkg::PERIOD_W-1:0]        period_front_right,
  output logic [msrg_pkg::PERIOD_W-1:0]        period_rear_left,
  output logic [msrg_pkg::PERIOD_W-1:0]        period_rear_right
);
  import msrg_pkg::*;

  localparam int WHEEL_W    = 10 + FRACTION_BITS;
  localparam int PROD_W     = WHEEL_W + COEF_W;
  localparam int ACC_W      = PROD_W + 1;
  localparam int SHR_W      = ACC_W - COEF_SHIFT;
  localparam int DIVISOR_W  = FRACTION_BITS + FULL_SPEED_BITS;
  localparam int DIVIDEND_W = FRACTION_BITS + DIVIDEND_SCALE_BITS;
  localparam int PSUM_W     = PERIOD_W + 1;

  localparam logic signed [WHEEL_W-1:0] WHEEL_MAX = {1'b0, {(WHEEL_W-1){1'b1}}};
  localparam logic signed [WHEEL_W-1:0] WHEEL_MIN = {1'b1, {(WHEEL_W-1){1'b0}}};
  localparam logic [WHEEL_W-1:0] FULL_LIM = WHEEL_W'(FULL_SPEED_LIMIT) << FRACTION_BITS;
  localparam logic [WHEEL_W-1:0] STOP_LIM = WHEEL_W'(STOP_LIMIT) << FRACTION_BITS;
  localparam logic [COUNTER_BITS-1:0] CNT_MAX = {COUNTER_BITS{1'b1}};

  // configuration
  logic [7:0]          time_factor;
  logic [7:0]          max_speed;
  logic [PERIOD_W-1:0] upper_limit_delay;

  // captured transaction
  logic                    req_tick;
  logic signed [CMD_W-1:0] rot_q;
  logic signed [CMD_W-1:0] fwd_q;
  logic signed [CMD_W-1:0] lat_q;

  // wheel state
  logic [WHEEL_IDX_W-1:0]    wheel_idx;
  logic signed [WHEEL_W-1:0] smoothed_wheel [NUM_WHEELS];
  logic [COUNTER_BITS-1:0]   tick_counter   [NUM_WHEELS];
  logic [NUM_WHEELS-1:0]     step_level;
  logic [PERIOD_W-1:0]       half_period    [NUM_WHEELS];

  // working signals
  logic signed [PROD_W-1:0]       prod;
  logic signed [PROD_W-1:0]       prod_next;
  logic signed [WHEEL_W-1:0]      wheel_cur;
  logic signed [TGT_W-1:0]        r_ext;
  logic signed [TGT_W-1:0]        f_ext;
  logic signed [TGT_W-1:0]        l_ext;
  logic signed [TGT_W-1:0]        tgt_cur;
  logic signed [TGT_W+COEF_W-1:0] tmul;
  logic signed [ACC_W-1:0]        acc;
  logic signed [SHR_W-1:0]        shr;
  logic signed [WHEEL_W-1:0]      filt_next;
  logic [WHEEL_W-1:0]             mag;
  logic                           band_fast;
  logic                           band_stop;
  logic [DIVIDEND_SCALE_BITS-1:0] tf_scaled;
  logic [DIVIDEND_W-1:0]          dividend;
  logic                           div_start;
  logic                           div_busy;
  logic [QUOT_BITS-1:0]           quotient;
  logic [PSUM_W-1:0]              p_sum;
  logic [PERIOD_W-1:0]            p_clamped;
  logic [COUNTER_BITS-1:0]        cnt_inc        [NUM_WHEELS];
  logic [NUM_WHEELS-1:0]          wrap;
  logic [NUM_WHEELS-1:0]          dir_now;

  // wheel mix for the selected wheel
  assign wheel_cur = smoothed_wheel[wheel_idx];
  assign r_ext     = TGT_W'(rot_q);
  assign f_ext     = TGT_W'(fwd_q);
  assign l_ext     = TGT_W'(lat_q);

  always_comb begin
    unique case (wheel_idx)
      2'd0:    tgt_cur = r_ext + f_ext + l_ext;
      2'd1:    tgt_cur = f_ext - r_ext - l_ext;
      2'd2:    tgt_cur = r_ext + f_ext - l_ext;
      default: tgt_cur = f_ext - r_ext + l_ext;
    endcase
  end

  // filter: old weight product first, then target term, rounding and saturation
  assign prod_next = wheel_cur * $signed(COEF_W'(COEF_OLD));
  assign tmul      = tgt_cur * $signed(COEF_W'(COEF_NEW));
  assign acc       = ACC_W'(prod) + (ACC_W'(tmul) <<< FRACTION_BITS) + ACC_W'(ROUND_BIAS);
  assign shr       = SHR_W'(acc >>> COEF_SHIFT);

  always_comb begin
    if (shr > SHR_W'(WHEEL_MAX)) begin
      filt_next = WHEEL_MAX;
    end else if (shr < SHR_W'(WHEEL_MIN)) begin
      filt_next = WHEEL_MIN;
    end else begin
      filt_next = WHEEL_W'(shr);
    end
  end

  // speed band of the selected wheel
  assign mag       = wheel_cur[WHEEL_W-1] ? WHEEL_W'(~wheel_cur + 1'b1) : WHEEL_W'(wheel_cur);
  assign band_fast = (mag > FULL_LIM);
  assign band_stop = (mag <= STOP_LIM);

  // period curve divider
  assign tf_scaled = DIVIDEND_SCALE_BITS'(time_factor)
                   * DIVIDEND_SCALE_BITS'(FULL_SPEED_LIMIT);
  assign dividend  = {tf_scaled, {FRACTION_BITS{1'b0}}};
  assign div_start = (ctrl.op == OP_BAND) && !band_fast && !band_stop;

  msrg_div #(
    .DIVIDEND_W(DIVIDEND_W),
    .DIVISOR_W (DIVISOR_W),
    .QUOT_W    (QUOT_BITS)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(dividend),
    .divisor (mag[DIVISOR_W-1:0]),
    .busy    (div_busy),
    .quotient(quotient)
  );

  // middle band period with upper limit
  assign p_sum     = PSUM_W'(quotient) + PSUM_W'(max_speed) - PSUM_W'(time_factor);
  assign p_clamped = (p_sum > PSUM_W'(upper_limit_delay)) ? upper_limit_delay
                                                           : p_sum[PERIOD_W-1:0];

  // tick lanes
  always_comb begin
    for (int i = 0; i < NUM_WHEELS; i++) begin
      cnt_inc[i] = (tick_counter[i] < CNT_MAX) ? tick_counter[i] + COUNTER_BITS'(1)
                                               : tick_counter[i];
      wrap[i]    = (half_period[i] != '0) && (cnt_inc[i] > COUNTER_BITS'(half_period[i]));
    end
  end

  // direction pins: left wheels high when negative, right wheels when nonnegative
  always_comb begin
    for (int i = 0; i < NUM_WHEELS; i++) begin
      dir_now[i] = ((i % 2) == 0) ? smoothed_wheel[i][WHEEL_W-1]
                                  : !smoothed_wheel[i][WHEEL_W-1];
    end
  end

  // status to sequencer
  assign stat.req_tick   = req_tick;
  assign stat.band_edge  = band_fast || band_stop;
  assign stat.div_busy   = div_busy;
  assign stat.last_wheel = (wheel_idx == WHEEL_IDX_W'(NUM_WHEELS - 1));
  assign stat.out_busy   = out_valid && !out_ready;

  // configuration and wheel state
  always_ff @(posedge clk) begin
    if (rst) begin
      time_factor       <= 8'd50;
      max_speed         <= 8'd8;
      upper_limit_delay <= 12'd300;
      req_tick          <= 1'b0;
      wheel_idx         <= '0;
      step_level        <= '0;
      out_valid         <= 1'b0;
      for (int i = 0; i < NUM_WHEELS; i++) begin
        smoothed_wheel[i] <= '0;
        tick_counter[i]   <= '0;
        half_period[i]    <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_TIME_FACTOR: time_factor       <= cfg_data[7:0];
          CFG_MAX_SPEED:   max_speed         <= cfg_data[7:0];
          CFG_UPPER_LIMIT: upper_limit_delay <= cfg_data[PERIOD_W-1:0];
          default:         ;
        endcase
      end
      if (ctrl.accept) begin
        req_tick  <= req_type;
        wheel_idx <= '0;
      end
      unique case (ctrl.op)
        OP_FILT: smoothed_wheel[wheel_idx] <= filt_next;
        OP_BAND: begin
          if (band_fast) begin
            half_period[wheel_idx] <= PERIOD_W'(max_speed);
          end else if (band_stop) begin
            half_period[wheel_idx] <= '0;
          end
        end
        OP_PERIOD:     half_period[wheel_idx] <= p_clamped;
        OP_NEXT_WHEEL: wheel_idx <= wheel_idx + WHEEL_IDX_W'(1);
        OP_TICK: begin
          for (int i = 0; i < NUM_WHEELS; i++) begin
            tick_counter[i] <= wrap[i] ? '0 : cnt_inc[i];
            step_level[i]   <= step_level[i] ^ wrap[i];
          end
        end
        default: ;
      endcase
      if (ctrl.op == OP_EMIT) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload: captured commands, product and result register
  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      rot_q <= rotation;
      fwd_q <= forward;
      lat_q <= lateral;
    end
    if (ctrl.op == OP_MUL) begin
      prod <= prod_next;
    end
    if (ctrl.op == OP_EMIT) begin
      step_levels        <= step_level;
      direction_levels   <= dir_now;
      period_front_left  <= half_period[0];
      period_front_right <= half_period[1];
      period_rear_left   <= half_period[2];
      period_rear_right  <= half_period[3];
    end
  end

endmodule

// ===== src/mecanum_step_rate_generator.sv =====
`timescale 1ns / 1ps
// Mecanum wheel mixer with step pulse generation.
// Input channel (in_valid/in_ready): req_type 0 carries a setpoint transaction
// (rotation, forward, lateral) that updates the four smoothed wheel values and
// their step half-periods; req_type 1 is one timer tick that advances the four
// tick counters and toggles step pins whose counter passed its half-period.
// Output channel (out_valid/out_ready): one result transaction per input
// transaction, holding step pins, direction pins and the four half-periods.
// Configuration: cfg_we/cfg_addr/cfg_data, written only while idle; the user
// must keep to this, as the block itself does not enforce it.
// Sequencing: a microcoded sequencer runs each transaction. A tick advances
// the tick lanes. A setpoint runs multiply, filter and band steps per wheel;
// in the middle band it waits for the restoring divider and writes the period.
// The next transaction is accepted once the result is in the output register.
// If the receiver stalls, the result holds and the following transaction is
// worked; the sequencer waits before its emit step until the register is free.
// Reset: synchronous; clears wheel state, counters, step state, half-periods
// and loads the register defaults (time factor 50, max speed 8, limit 300).
// depends on msrg_pkg, msrg_seq, msrg_datapath

module mecanum_step_rate_generator #(
  parameter int FRACTION_BITS = msrg_pkg::FRACTION_BITS_DEF,
  parameter int COUNTER_BITS  = msrg_pkg::COUNTER_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [msrg_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  logic [msrg_pkg::CFG_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              req_type,
  input  logic signed [msrg_pkg::CMD_W-1:0] rotation,
  input  logic signed [msrg_pkg::CMD_W-1:0] forward,
  input  logic signed [msrg_pkg::CMD_W-1:0] lateral,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [msrg_pkg::NUM_WHEELS-1:0]   step_levels,
  output logic [msrg_pkg::NUM_WHEELS-1:0]   direction_levels,
  output logic [msrg_pkg::PERIOD_W-1:0]     period_front_left,
  output logic [msrg_pkg::PERIOD_W-1:0]     period_front_right,
  output logic [msrg_pkg::PERIOD_W-1:0]     period_rear_left,
  output logic [msrg_pkg::PERIOD_W-1:0]     period_rear_right
);
  import msrg_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  // sequencer
  msrg_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .stat    (stat),
    .ctrl    (ctrl)
  );

  // datapath
  msrg_datapath #(
    .FRACTION_BITS(FRACTION_BITS),
    .COUNTER_BITS (COUNTER_BITS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .ctrl              (ctrl),
    .stat              (stat),
    .cfg_we            (cfg_we),
    .cfg_addr          (cfg_addr),
    .cfg_data          (cfg_data),
    .req_type          (req_type),
    .rotation          (rotation),
    .forward           (forward),
    .lateral           (lateral),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .step_levels       (step_levels),
    .direction_levels  (direction_levels),
    .period_front_left (period_front_left),
    .period_front_right(period_front_right),
    .period_rear_left  (period_rear_left),
    .period_rear_right (period_rear_right)
  );

`ifndef SYNTHESIS
  // one transaction at a time: no acceptance right after an acceptance
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted twice in a row");

  // result register must be free when a result is written
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    ctrl.op == OP_EMIT |-> !out_valid)
    else $error("result written over a pending result");

  // result valid only rises after an emit step
  a_rise_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(ctrl.op == OP_EMIT))
    else $error("result valid without emit step");

  // while dividing the sequencer waits and takes no input
  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    stat.div_busy |-> ctrl.op == OP_NOP && !in_ready)
    else $error("sequencer moved on during division");
`endif

endmodule
